// ===== src/fdsa_pkg.sv =====
// Package with shared types, opcodes and constants for the Forth data stack ALU.
package fdsa_pkg;

	localparam int StackDepthDefault = 64;

	typedef enum logic [4:0] {
		OP_PUSH  = 5'd0,
		OP_ADD   = 5'd1,
		OP_SUB   = 5'd2,
		OP_MUL   = 5'd3,
		OP_DIV   = 5'd4,
		OP_MOD   = 5'd5,
		OP_NEG   = 5'd6,
		OP_GT    = 5'd7,
		OP_GE    = 5'd8,
		OP_LT    = 5'd9,
		OP_LE    = 5'd10,
		OP_EQ    = 5'd11,
		OP_NE    = 5'd12,
		OP_AND   = 5'd13,
		OP_OR    = 5'd14,
		OP_NOT   = 5'd15,
		OP_DUP   = 5'd16,
		OP_DROP  = 5'd17,
		OP_SWAP  = 5'd18,
		OP_ROT   = 5'd19,
		OP_PRINT = 5'd20
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_UNDER = 2'd1,
		ST_OVER  = 2'd2,
		ST_DIVZ  = 2'd3
	} status_t;

	typedef struct packed {
		logic [4:0]         op;
		logic signed [31:0] literal;
	} in_beat_t;

	typedef struct packed {
		logic signed [31:0] top_value;
		logic [6:0]         depth;
		logic [1:0]         status;
		logic               print_valid;
		logic signed [31:0] print_value;
	} out_beat_t;

	// Divider handshake between the sequencer and the divide unit.
	typedef struct packed {
		logic start;
		logic is_mod;
	} div_ctl_t;

endpackage

// ===== src/fdsa_div.sv =====
// Iterative signed 32-bit divider, one quotient bit per cycle.
module fdsa_div import fdsa_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  div_ctl_t    ctl,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic        done,
	output logic [31:0] result
);
	logic [31:0] quo_q, rem_q, div_q;
	logic [5:0]  cnt_q;
	logic        busy_q, neg_q, mod_q;
	logic [32:0] trial;

	assign trial = {rem_q, quo_q[31]} - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd32;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			quo_q <= a[31] ? 32'd0 - a : a;
			div_q <= b[31] ? 32'd0 - b : b;
			rem_q <= '0;
			mod_q <= ctl.is_mod;
			neg_q <= ctl.is_mod ? a[31] : (a[31] ^ b[31]);
		end else if (busy_q) begin
			if (!trial[32]) begin
				rem_q <= trial[31:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= {rem_q[30:0], quo_q[31]};
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

	logic [31:0] mag_res;
	assign mag_res = mod_q ? rem_q : quo_q;
	assign result  = neg_q ? 32'd0 - mag_res : mag_res;
endmodule

// ===== src/fdsa_alu.sv =====
// Combinational ALU for add, sub, the compares, and, or, neg and not.
module fdsa_alu import fdsa_pkg::*; (
	input  logic [4:0]  op,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic [31:0] r
);
	logic gt_ab, gt_ba;
	assign gt_ab = $signed(a) > $signed(b);
	assign gt_ba = $signed(b) > $signed(a);

	always_comb begin
		r = '0;
		unique case (op)
			OP_ADD:  r = a + b;
			OP_SUB:  r = a - b;
			OP_GT:   r = {31'd0, gt_ab};
			OP_GE:   r = {31'd0, !gt_ba};
			OP_LT:   r = {31'd0, gt_ba};
			OP_LE:   r = {31'd0, !gt_ab};
			OP_EQ:   r = {31'd0, a == b};
			OP_NE:   r = {31'd0, a != b};
			OP_AND:  r = {31'd0, (a != 0) && (b != 0)};
			OP_OR:   r = {31'd0, (a != 0) || (b != 0)};
			OP_NEG:  r = 32'd0 - b;
			OP_NOT:  r = {31'd0, b == 0};
			default: r = '0;
		endcase
	end
endmodule

// ===== src/forth_data_stack_alu_top.sv =====
// Top level of the Forth data stack with integer ALU.
//
//   Channel | Direction | Handshake           | Payload
//   in      | input     | in_valid/in_ready   | in_beat_t  (op, literal)
//   out     | output    | out_valid/out_ready | out_beat_t (top, depth, status, print)
//
// The top three stack words live in registers (t0_q, t1_q, t2_q); the deeper
// entries live in a synchronous memory with a registered read port.
// Every beat passes S_EXEC and waits in S_DONE until the output register is
// free. Push, dup, neg, not, swap, rot, unused codes and faulting ops go from
// S_EXEC straight to S_DONE. Drop, print and the other two-operand ops pass
// S_FILL, which refills t2 from the memory. Multiply first passes S_MUL
// (registered product); div and mod wait in S_DIV for the divider's 32 steps.
// Reset clears the count, the output register and the state machine; the
// memory is not cleared. One beat is processed at a time and a new beat is
// taken the cycle after a result is posted; a result that waits at the output
// lets the next beat run and holds it in its last cycle until the output frees.
module forth_data_stack_alu_top import fdsa_pkg::*; #(
	parameter int STACK_DEPTH = StackDepthDefault
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_beat_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_beat_t out_data
);
	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam int AW = (STACK_DEPTH > 4) ? $clog2(STACK_DEPTH - 3) : 1;
	localparam int MEMD = (STACK_DEPTH > 3) ? STACK_DEPTH - 3 : 1;

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_EXEC = 6'b000010,
		S_MUL  = 6'b000100,
		S_DIV  = 6'b001000,
		S_FILL = 6'b010000,
		S_DONE = 6'b100000
	} state_t;

	state_t      state_q;
	logic [4:0]  op_q;
	logic [31:0] lit_q;
	logic [31:0] t0_q, t1_q, t2_q;
	logic [CW-1:0] cnt_q;
	logic [31:0] mem [MEMD];
	logic [31:0] rd_q;
	logic        we;
	logic [AW-1:0] waddr, raddr;
	logic [31:0] wdata;
	logic [31:0] prod_q, alu_r, div_r;
	logic        div_done;
	div_ctl_t    dctl;
	logic        pv_q;
	logic [31:0] pval_q;
	logic [1:0]  st_q;
	status_t     st_next;
	logic        fire_out;

	// Memory entry i holds stack word i (bottom = 0); index is count-4 for
	// the word below t2.
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rd_q <= mem[raddr];
	end

	fdsa_alu u_alu (.op(op_q), .a(t1_q), .b(t0_q), .r(alu_r));
	fdsa_div u_div (.clk(clk), .arst_n(arst_n), .ctl(dctl), .a(t1_q), .b(t0_q),
		.done(div_done), .result(div_r));

	logic [1:0] need;
	always_comb begin
		need = 2'd0;
		unique case (op_q)
			OP_NEG, OP_NOT, OP_DUP, OP_DROP, OP_PRINT: need = 2'd1;
			OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_GT, OP_GE, OP_LT, OP_LE,
			OP_EQ, OP_NE, OP_AND, OP_OR, OP_SWAP: need = 2'd2;
			OP_ROT: need = 2'd3;
			default: need = 2'd0;
		endcase
	end

	logic pop1, push1;
	assign pop1 = (op_q == OP_DROP) || (op_q == OP_PRINT) ||
		((op_q >= OP_ADD) && (op_q <= OP_OR) && (op_q != OP_NEG));
	assign push1 = (op_q == OP_PUSH) || (op_q == OP_DUP);

	// Spill t2 on push, read word below t2 on pop.
	logic [CW-1:0] cm3, cm4;
	assign cm3 = cnt_q - CW'(3);
	assign cm4 = cnt_q - CW'(4);
	assign waddr = cm3[AW-1:0];
	assign raddr = cm4[AW-1:0];
	assign wdata = t2_q;
	assign we = (state_q == S_EXEC) && push1 && (cnt_q >= CW'(3)) &&
		(cnt_q < CW'(STACK_DEPTH)) && (st_next == ST_OK);

	always_comb begin
		if (op_q > OP_PRINT) st_next = ST_OK;
		else if (cnt_q < CW'(need)) st_next = ST_UNDER;
		else if (push1 && cnt_q >= CW'(STACK_DEPTH)) st_next = ST_OVER;
		else if ((op_q == OP_DIV || op_q == OP_MOD) && t0_q == 32'd0) st_next = ST_DIVZ;
		else st_next = ST_OK;
	end

	assign dctl.start  = (state_q == S_EXEC) && (st_next == ST_OK) &&
		(op_q == OP_DIV || op_q == OP_MOD);
	assign dctl.is_mod = (op_q == OP_MOD);

	// The finished beat moves into the output register once it is free.
	assign fire_out = (state_q == S_DONE) && (!out_valid || out_ready);
	assign in_ready = (state_q == S_IDLE);

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid && in_ready) begin
			op_q  <= in_data.op;
			lit_q <= in_data.literal;
		end
		prod_q <= t1_q * t0_q;
	end

	// Steps the state machine, keeps the stack count and loads the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cnt_q     <= '0;
			out_valid <= 1'b0;
			out_data  <= '0;
			st_q      <= ST_OK;
			pv_q      <= 1'b0;
		end else begin
			out_valid <= fire_out || (out_valid && !out_ready);
			if (fire_out) begin
				out_data.top_value   <= (cnt_q != '0) ? t0_q : 32'd0;
				out_data.depth       <= 7'(cnt_q);
				out_data.status      <= st_q;
				out_data.print_valid <= pv_q;
				out_data.print_value <= pv_q ? pval_q : 32'd0;
			end
			unique case (state_q)
				S_IDLE: if (in_valid && in_ready) state_q <= S_EXEC;
				S_EXEC: begin
					st_q <= st_next;
					pv_q <= 1'b0;
					if (st_next != ST_OK || op_q > OP_PRINT) state_q <= S_DONE;
					else begin
						priority case (1'b1)
							push1: begin
								cnt_q <= cnt_q + CW'(1);
								state_q <= S_DONE;
							end
							op_q == OP_MUL: state_q <= S_MUL;
							op_q == OP_DIV || op_q == OP_MOD: state_q <= S_DIV;
							pop1: begin
								if (op_q == OP_PRINT) pv_q <= 1'b1;
								state_q <= S_FILL;
							end
							default: state_q <= S_DONE;
						endcase
					end
				end
				S_MUL: state_q <= S_FILL;
				S_DIV: if (div_done) state_q <= S_FILL;
				S_FILL: begin
					cnt_q <= cnt_q - CW'(1);
					state_q <= S_DONE;
				end
				S_DONE: if (fire_out) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Stack top registers.
	always_ff @(posedge clk) begin
		if (state_q == S_EXEC && st_next == ST_OK && op_q <= OP_PRINT) begin
			unique case (op_q)
				OP_PUSH, OP_DUP: begin
					t0_q <= (op_q == OP_PUSH) ? lit_q : t0_q;
					t1_q <= t0_q;
					t2_q <= t1_q;
				end
				OP_NEG, OP_NOT: t0_q <= alu_r;
				OP_SWAP: begin
					t0_q <= t1_q;
					t1_q <= t0_q;
				end
				OP_ROT: begin
					t0_q <= t2_q;
					t1_q <= t0_q;
					t2_q <= t1_q;
				end
				OP_DROP, OP_PRINT: begin
					pval_q <= t0_q;
					t0_q <= t1_q;
				end
				OP_MUL, OP_DIV, OP_MOD: ;
				default: t0_q <= alu_r;
			endcase
		end else if (state_q == S_FILL) begin
			if (op_q == OP_MUL) t0_q <= prod_q;
			else if (op_q == OP_DIV || op_q == OP_MOD) t0_q <= div_r;
			t1_q <= t2_q;
			t2_q <= rd_q;
		end
	end
endmodule

// ===== src/fdsa_checker.sv =====
// Port-level checker for the Forth data stack ALU, bound to the top level.
module fdsa_checker import fdsa_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_ready,
	input in_beat_t  in_data,
	input logic      out_valid,
	input logic      out_ready,
	input out_beat_t out_data
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output beat dropped while stalled");
	a_print_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.print_valid |-> out_data.print_value == 32'd0)
		else $error("print value without print");
	a_empty_top: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.depth == 7'd0 |-> out_data.top_value == 32'd0)
		else $error("nonzero top on empty stack");
	a_one_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second beat accepted while busy");
	a_print_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.print_valid |-> out_data.status == ST_OK)
		else $error("print reported with fault status");
endmodule

bind forth_data_stack_alu_top fdsa_checker u_fdsa_checker (.*);

// ===== sim/tb.sv =====
// Self-checking testbench for the Forth data stack with integer ALU.
module tb;
	import fdsa_pkg::*;

	localparam int DEPTH = StackDepthDefault;
	localparam int RANDOM_BEATS = 1750;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	in_beat_t  in_data;
	logic      out_valid;
	logic      out_ready;
	out_beat_t out_data;

	forth_data_stack_alu_top #(.STACK_DEPTH(DEPTH)) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	// Shadow of the stack, updated as each beat is accepted.
	logic [31:0] shadow_stack [DEPTH];
	int          shadow_count;

	in_beat_t  pending_beats [$];
	out_beat_t expected_results [$];
	int        error_count;
	bit        hold_sender;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic logic [31:0] magnitude(logic [31:0] v);
		return v[31] ? 32'd0 - v : v;
	endfunction

	// Works out the response to one instruction and updates the shadow stack.
	function automatic out_beat_t execute_op(in_beat_t beat);
		out_beat_t   res;
		int          need;
		logic [31:0] a, b, r, t;
		logic [4:0]  op;
		op = beat.op;
		res = '0;
		res.status = ST_OK;
		case (op)
			OP_NEG, OP_NOT, OP_DUP, OP_DROP, OP_PRINT: need = 1;
			OP_ROT: need = 3;
			OP_PUSH: need = 0;
			default: need = (op <= OP_SWAP) ? 2 : 0;
		endcase
		b = (shadow_count > 0) ? shadow_stack[shadow_count-1] : 32'd0;
		a = (shadow_count > 1) ? shadow_stack[shadow_count-2] : 32'd0;
		if (op > OP_PRINT) begin
			// Unused codes do nothing.
		end else if (shadow_count < need) begin
			res.status = ST_UNDER;
		end else if ((op == OP_PUSH || op == OP_DUP) && shadow_count >= DEPTH) begin
			res.status = ST_OVER;
		end else if ((op == OP_DIV || op == OP_MOD) && b == 32'd0) begin
			res.status = ST_DIVZ;
		end else begin
			case (op)
				OP_PUSH: begin
					shadow_stack[shadow_count] = beat.literal;
					shadow_count++;
				end
				OP_DUP: begin
					shadow_stack[shadow_count] = b;
					shadow_count++;
				end
				OP_DROP: shadow_count--;
				OP_PRINT: begin
					res.print_valid = 1'b1;
					res.print_value = b;
					shadow_count--;
				end
				OP_NEG: shadow_stack[shadow_count-1] = 32'd0 - b;
				OP_NOT: shadow_stack[shadow_count-1] = 32'(b == 32'd0);
				OP_SWAP: begin
					shadow_stack[shadow_count-1] = a;
					shadow_stack[shadow_count-2] = b;
				end
				OP_ROT: begin
					t = shadow_stack[shadow_count-3];
					shadow_stack[shadow_count-3] = a;
					shadow_stack[shadow_count-2] = b;
					shadow_stack[shadow_count-1] = t;
				end
				default: begin
					case (op)
						OP_ADD: r = a + b;
						OP_SUB: r = a - b;
						OP_MUL: r = a * b;
						OP_DIV: begin
							r = magnitude(a) / magnitude(b);
							if (a[31] ^ b[31]) r = 32'd0 - r;
						end
						OP_MOD: begin
							r = magnitude(a) % magnitude(b);
							if (a[31]) r = 32'd0 - r;
						end
						OP_GT: r = 32'($signed(a) > $signed(b));
						OP_GE: r = 32'($signed(a) >= $signed(b));
						OP_LT: r = 32'($signed(a) < $signed(b));
						OP_LE: r = 32'($signed(a) <= $signed(b));
						OP_EQ: r = 32'(a == b);
						OP_NE: r = 32'(a != b);
						OP_AND: r = 32'(a != 32'd0 && b != 32'd0);
						default: r = 32'(a != 32'd0 || b != 32'd0);
					endcase
					shadow_count--;
					shadow_stack[shadow_count-1] = r;
				end
			endcase
		end
		res.top_value = (shadow_count > 0) ? shadow_stack[shadow_count-1] : 32'd0;
		res.depth = shadow_count[6:0];
		return res;
	endfunction

	function automatic in_beat_t make_beat(logic [4:0] op, logic [31:0] lit);
		in_beat_t beat;
		beat.op = op;
		beat.literal = lit;
		return beat;
	endfunction

	// Appends one beat to the end of the pending queue.
	task automatic add_beat(logic [4:0] op, logic [31:0] lit);
		pending_beats.insert(pending_beats.size(), make_beat(op, lit));
	endtask

	// Operands that stress sign, zero and wrap behavior.
	function automatic logic [31:0] random_word();
		case ($urandom_range(0, 7))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'hffff_ffff;
			3: return 32'd0;
			4: return $urandom_range(0, 9);
			5: return 32'd0 - $urandom_range(1, 9);
			default: return $urandom();
		endcase
	endfunction

	// Driver: presents queued beats after a random gap, holding each until
	// accepted. The gap counter is reloaded each time a new beat is presented.
	int send_gap;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data  <= '0;
			send_gap <= 0;
		end else if (in_valid && !in_ready) begin
			// Beat held until the block takes it.
		end else begin
			if (in_valid) begin
				expected_results.insert(expected_results.size(), execute_op(in_data));
			end
			if (send_gap > 0) begin
				in_valid <= 1'b0;
				send_gap <= send_gap - 1;
			end else if (pending_beats.size() > 0 && !hold_sender) begin
				in_valid <= 1'b1;
				in_data  <= pending_beats[0];
				pending_beats.delete(0);
				send_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Monitor: random ready with occasional back-pressure, checks each beat.
	int        recv_gap;
	out_beat_t expected;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			recv_gap  <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					$error("unexpected result beat: top %0h depth %0d",
						out_data.top_value, out_data.depth);
					error_count++;
				end else begin
					expected = expected_results[0];
					expected_results.delete(0);
					if (out_data.top_value !== expected.top_value) begin
						$error("top_value: expected %0h, got %0h",
							expected.top_value, out_data.top_value);
						error_count++;
					end
					if (out_data.depth !== expected.depth) begin
						$error("depth: expected %0d, got %0d",
							expected.depth, out_data.depth);
						error_count++;
					end
					if (out_data.status !== expected.status) begin
						$error("status: expected %0d, got %0d",
							expected.status, out_data.status);
						error_count++;
					end
					if (out_data.print_valid !== expected.print_valid) begin
						$error("print_valid: expected %0d, got %0d",
							expected.print_valid, out_data.print_valid);
						error_count++;
					end
					if (out_data.print_value !== expected.print_value) begin
						$error("print_value: expected %0h, got %0h",
							expected.print_value, out_data.print_value);
						error_count++;
					end
				end
			end
			if (recv_gap > 0) begin
				out_ready <= 1'b0;
				recv_gap  <= recv_gap - 1;
			end else begin
				out_ready <= 1'b1;
				if (out_valid && out_ready)
					recv_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
			end
		end
	end

	// Stimulus. The generator keeps its own rough depth estimate so that
	// random programs drift between empty and full instead of sticking.
	int model_depth;
	int target;
	initial begin
		logic [4:0] op;
		error_count = 0;
		hold_sender = 1'b0;
		shadow_count = 0;
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: underflow on an empty stack, divide extremes, rot, print.
		add_beat(OP_DROP, 32'd0);
		add_beat(OP_ROT, 32'd0);
		add_beat(OP_PUSH, 32'h8000_0000);
		add_beat(OP_PUSH, 32'hffff_ffff);
		add_beat(OP_ROT, 32'd0);
		add_beat(OP_DIV, 32'd0);
		add_beat(OP_PUSH, 32'h8000_0000);
		add_beat(OP_PUSH, 32'hffff_ffff);
		add_beat(OP_MOD, 32'd0);
		add_beat(OP_PUSH, 32'd0);
		add_beat(OP_DIV, 32'd0);
		add_beat(OP_MOD, 32'd0);
		add_beat(OP_PUSH, 32'h7fff_ffff);
		add_beat(OP_ROT, 32'd0);
		add_beat(OP_PRINT, 32'd0);
		add_beat(5'd31, 32'hffff_ffff);
		for (int i = 1; i <= 21; i++)
			add_beat(i[4:0], 32'h5a5a_a5a5);
		wait (pending_beats.size() == 0);

		// Fill the stack to overflow, then hold the sender until idle.
		for (int i = 0; i < DEPTH + 2; i++)
			add_beat(OP_PUSH, random_word());
		add_beat(OP_DUP, 32'd0);
		wait (pending_beats.size() == 0);
		hold_sender = 1'b1;
		wait (!in_valid && expected_results.size() == 0);
		hold_sender <= 1'b0;
		model_depth = DEPTH;

		// Random programs: mostly valid ops on the current stack.
		target = $urandom_range(0, DEPTH);
		for (int i = 0; i < RANDOM_BEATS; i++) begin
			if ($urandom_range(0, 99) == 0) target = $urandom_range(0, DEPTH);
			if ($urandom_range(0, 19) == 0)
				op = 5'($urandom_range(0, 31));
			else if (model_depth < target && $urandom_range(0, 2) != 0)
				op = ($urandom_range(0, 3) == 0) ? OP_DUP : OP_PUSH;
			else
				op = 5'($urandom_range(0, 20));
			add_beat(op, random_word());
			// Rough depth tracking; exactness is not needed here.
			case (op)
				OP_PUSH, OP_DUP: if (model_depth < DEPTH) model_depth++;
				OP_NEG, OP_NOT, OP_SWAP, OP_ROT: ;
				default: if (op <= OP_PRINT && model_depth > 0) model_depth--;
			endcase
			if (pending_beats.size() > 8) wait (pending_beats.size() <= 8);
		end
		wait (pending_beats.size() == 0);
		wait (!in_valid && expected_results.size() == 0);
		repeat (60) @(posedge clk);
		if (error_count == 0 && expected_results.size() == 0)
			$display("forth_data_stack_alu_top regression: pass");
		else
			$display("forth_data_stack_alu_top regression: fail");
		$finish;
	end

	// Worst case: every beat a divide plus both idle gaps.
	initial begin
		#10000000;
		$display("forth_data_stack_alu_top regression: fail");
		$finish;
	end
endmodule

// ===== forth_data_stack_alu_top.f =====
src/fdsa_pkg.sv
src/fdsa_div.sv
src/fdsa_alu.sv
src/forth_data_stack_alu_top.sv
src/fdsa_checker.sv
sim/tb.sv
